@@ rtl/core/i2f_pkg.sv @@
package i2f_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned FRAC_BITS = 23;
   localparam int unsigned EXP_W     = 8;
   localparam int unsigned LZC_W     = 5;
   // biased exponent of a value whose leading one sits in bit 31
   localparam logic [EXP_W-1:0] TOP_EXP = 8'd158;

   typedef logic [WORD_W-1:0] word_type;

endpackage

@@ rtl/core/i2f_req_if.sv @@
interface i2f_req_if import i2f_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] int_value;

   modport source (output valid, output int_value, input ready);
   modport sink   (input valid, input int_value, output ready);
endinterface

@@ rtl/core/i2f_rsp_if.sv @@
interface i2f_rsp_if import i2f_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type float_bits;

   modport source (output valid, output float_bits, input ready);
   modport sink   (input valid, input float_bits, output ready);
endinterface

@@ rtl/core/int32_to_float32_convert_top.sv @@
// Signed 32-bit integer to IEEE 754 binary32, round to nearest even. Zero gives +0 and
// -2^31 converts exactly. Takes one request per cycle while the result side is not stalled,
// through four pipeline stages (sign/negate, leading-zero count, normalizing shift,
// round and pack). Each stage holds its item while the next one is full, so a stall
// at the result side backs up one stage at a time and empty stages keep accepting.
module int32_to_float32_convert_top
   import i2f_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   i2f_req_if.sink     req,
   i2f_rsp_if.source   rsp
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || rsp.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage 1: sign and magnitude
   word_type mag_in, mag1_ff;
   logic     sign1_ff;

   assign mag_in = req.int_value[WORD_W-1] ? (word_type'(0) - word_type'(req.int_value))
                                            : word_type'(req.int_value);

   always_ff @(posedge clock) begin
      if (en1) begin
         mag1_ff  <= mag_in;
         sign1_ff <= req.int_value[WORD_W-1];
      end
   end

   // stage 2: leading-zero count
   logic [LZC_W-1:0] lzc_in, lzc2_ff;
   logic             zero_in, zero2_ff, sign2_ff;
   word_type         mag2_ff;

   always_comb begin
      word_type v;
      v      = mag1_ff;
      lzc_in = '0;
      for (int i = LZC_W-1; i >= 0; i--) begin
         if ((v >> (WORD_W - (1 << i))) == '0) begin
            lzc_in[i] = 1'b1;
            v = v << (1 << i);
         end
      end
   end

   assign zero_in = (mag1_ff == '0);

   always_ff @(posedge clock) begin
      if (en2) begin
         mag2_ff  <= mag1_ff;
         lzc2_ff  <= lzc_in;
         zero2_ff <= zero_in;
         sign2_ff <= sign1_ff;
      end
   end

   // stage 3: normalize so the leading one lands in bit 31
   word_type         norm3_ff;
   logic [EXP_W-1:0] exp3_ff;
   logic             zero3_ff, sign3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         norm3_ff <= mag2_ff << lzc2_ff;
         exp3_ff  <= TOP_EXP - EXP_W'(lzc2_ff);
         zero3_ff <= zero2_ff;
         sign3_ff <= sign2_ff;
      end
   end

   // stage 4: round on the eight bits below the fraction; carry runs into the exponent
   localparam int unsigned DROP = WORD_W - 1 - FRAC_BITS;

   logic                       guard, sticky, lsb, round_up;
   logic [EXP_W+FRAC_BITS-1:0] packed_in;
   word_type                   out4_ff;

   assign lsb      = norm3_ff[DROP];
   assign guard    = norm3_ff[DROP-1];
   assign sticky   = |norm3_ff[DROP-2:0];
   assign round_up = guard && (sticky || lsb);
   assign packed_in = {exp3_ff, norm3_ff[WORD_W-2:DROP]}
                    + {{(EXP_W+FRAC_BITS-1){1'b0}}, round_up};

   always_ff @(posedge clock) begin
      if (en4) begin
         out4_ff <= zero3_ff ? '0 : {sign3_ff, packed_in};
      end
   end

   assign rsp.valid      = v4_ff;
   assign rsp.float_bits = out4_ff;

endmodule

@@ rtl/core/i2f_checker.sv @@
module i2f_checker
   import i2f_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input word_type rsp_float_bits
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   // largest magnitude is 2^31, so the exponent never passes 158
   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_float_bits[30:23] <= TOP_EXP)
      else $error("exponent out of range");

   // only zero has a zero exponent field, and it is always +0
   a_zero_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_float_bits[30:23] == '0 |-> rsp_float_bits == '0)
      else $error("malformed zero or denormal");

endmodule

bind int32_to_float32_convert_top i2f_checker u_i2f_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_float_bits (rsp.float_bits)
);

@@ tb/tb_int32_to_float32_convert_top.sv @@
`timescale 1ns / 1ps

module tb_int32_to_float32_convert_top;
   import i2f_pkg::*;

   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned PIPE_DEPTH  = 4;
   localparam int unsigned RANDOM_OPS  = 1528;

   typedef struct {
      logic signed [WORD_W-1:0] operand;
      word_type                 float_bits;
   } conversion_type;

   // Holds the expected binary32 patterns of accepted requests, oldest first.
   class conversion_scoreboard;
      conversion_type expected_q[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      function word_type predict_binary32(input logic signed [WORD_W-1:0] operand);
         logic             sgn;
         logic [WORD_W-1:0] mag;
         logic [WORD_W-1:0] sig;
         logic [WORD_W-1:0] tail_mask;
         logic              round_bit;
         logic              sticky;
         int                msb;
         int                sh;
         logic [EXP_W-1:0]  expo;
         if (operand == 0) begin
            return '0;
         end
         sgn = operand[WORD_W-1];
         // magnitude as unsigned, so -2^31 stays 0x80000000
         mag = sgn ? (~operand + 1'b1) : operand;
         msb = WORD_W - 1;
         while (!mag[msb]) begin
            msb--;
         end
         if (msb <= FRAC_BITS) begin
            sig = mag << (FRAC_BITS - msb);
         end else begin
            sh        = msb - FRAC_BITS;
            sig       = mag >> sh;
            round_bit = mag[sh-1];
            tail_mask = (32'd1 << (sh - 1)) - 32'd1;
            sticky    = |(mag & tail_mask);
            if (round_bit && (sticky || sig[0])) begin
               sig = sig + 32'd1;
            end
            if (sig[FRAC_BITS+1]) begin
               sig = sig >> 1;
               msb = msb + 1;
            end
         end
         expo = EXP_W'(msb + 127);
         return {sgn, expo, sig[FRAC_BITS-1:0]};
      endfunction

      function void note_request(input logic signed [WORD_W-1:0] operand);
         conversion_type entry;
         entry.operand    = operand;
         entry.float_bits = predict_binary32(operand);
         expected_q.push_back(entry);
      endfunction

      task report(input string msg);
         $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(input word_type got_bits);
         conversion_type entry;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected response float_bits=%08h", got_bits));
         end else begin
            entry = expected_q.pop_front();
            if (got_bits !== entry.float_bits) begin
               report($sformatf("int_value=%08h float_bits got %08h want %08h",
                                entry.operand, got_bits, entry.float_bits));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;

   i2f_req_if req_ch ();
   i2f_rsp_if rsp_ch ();

   int32_to_float32_convert_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   conversion_scoreboard sb;
   logic        req_idle;
   logic        rsp_idle;
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Ends the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("[int32_to_float32_convert_top] ERROR");
            $finish;
         end
      end
   end

   // Entered and left just after a falling edge.
   task automatic send_conversion(input logic signed [WORD_W-1:0] operand);
      int gap;
      gap = req_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.int_value <= operand;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_request(operand);
      @(negedge clock);
   endtask

   task automatic take_results();
      int stall;
      forever begin
         stall = rsp_idle ? $urandom_range(0, 17) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         sb.check_result(rsp_ch.float_bits);
         @(negedge clock);
      end
   endtask

   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      while (sb.expected_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic logic [WORD_W-1:0] random_operand();
      logic [WORD_W-1:0] val;
      logic [WORD_W-1:0] mask;
      logic [WORD_W-1:0] half;
      logic [WORD_W-1:0] tail;
      int                width;
      int                sh;
      case ($urandom_range(0, 3))
         0: begin
            val = $urandom;
         end
         1: begin
            // random magnitude with a chosen leading-one position
            width = $urandom_range(1, 32);
            mask  = (width == 32) ? '1 : ((32'd1 << width) - 32'd1);
            val   = ($urandom & mask) | (32'd1 << (width - 1));
         end
         2: begin
            // tail bits at or next to the halfway point, or all zero or all one
            width = $urandom_range(25, 32);
            sh    = width - 24;
            val   = ($urandom | 32'h8000_0000) >> (32 - width);
            mask  = (32'd1 << sh) - 32'd1;
            half  = 32'd1 << (sh - 1);
            case ($urandom_range(0, 4))
               0: tail = half;
               1: tail = half - 32'd1;
               2: tail = half + 32'd1;
               3: tail = '0;
               default: tail = mask;
            endcase
            val = (val & ~mask) | (tail & mask);
         end
         default: begin
            // near zero or near the exact-range boundary
            val = $urandom_range(0, 1) ? $urandom_range(0, 64)
                                       : (32'h0100_0000 + $urandom_range(0, 64) - 32);
         end
      endcase
      if ($urandom_range(0, 1)) begin
         val = ~val + 1'b1;
      end
      return val;
   endfunction

   logic [WORD_W-1:0] directed_ops[] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFE,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h00FF_FFFF, 32'hFF00_0001,
      32'h0100_0000, 32'h0100_0001, 32'h0100_0003, 32'h01FF_FFFF, 32'h7FFF_FFC0,
      32'h7FFF_FF40, 32'h0080_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0200_0001,
      32'h0300_0002, 32'hFE00_0003
   };

   initial begin
      sb = new();
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.int_value = '0;
      rsp_ch.ready     = 1'b0;
      req_idle         = 1'b1;
      rsp_idle         = 1'b1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      fork
         take_results();
      join_none

      foreach (directed_ops[i]) begin
         send_conversion(directed_ops[i]);
      end
      wait_until_drained();

      // four phases: idling on both sides, none, sender only, receiver only
      for (int phase = 0; phase < 4; phase++) begin
         req_idle = (phase == 0) || (phase == 2);
         rsp_idle = (phase == 0) || (phase == 3);
         for (int n = 0; n < RANDOM_OPS / 4; n++) begin
            send_conversion(random_operand());
         end
         wait_until_drained();
      end

      repeat (PIPE_DEPTH * 2) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         sb.report($sformatf("%0d responses never arrived", sb.expected_q.size()));
      end
      if (sb.mismatches == 0) begin
         $display("[int32_to_float32_convert_top] OK");
      end else begin
         $display("[int32_to_float32_convert_top] ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/i2f_pkg.sv
rtl/core/i2f_req_if.sv
rtl/core/i2f_rsp_if.sv
rtl/core/int32_to_float32_convert_top.sv
rtl/core/i2f_checker.sv
tb/tb_int32_to_float32_convert_top.sv
